@@ sv/ray_sphere_hit_assert.svh @@
// Assertion macros for the ray/sphere hit pipeline.
`ifndef RAY_SPHERE_HIT_ASSERT_SVH
`define RAY_SPHERE_HIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RSH_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSH_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ sv/rsh_pkg.sv @@
// Shared types and constants for the ray/sphere hit pipeline.
package rsh_pkg;

    localparam int CHUNK_BITS    = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int MATERIAL_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_RADIUS   = 3'd3,
        CFG_MATERIAL = 3'd4
    } cfg_idx_t;

endpackage

@@ sv/rsh_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, unsigned.
module rsh_div #(
    parameter int NW = 82,
    parameter int DW = 64
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    logic [NW-1:0] x_reg   [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [DW-1:0] den_reg [NW];

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [NW-1:0] x_in;
        logic [DW-1:0] r_in;
        logic [DW-1:0] d_in;
        logic [DW:0]   r_sh;
        logic          ge;

        if (g == 0) begin : g_first
            assign x_in = num;
            assign r_in = '0;
            assign d_in = den;
        end
        else begin : g_rest
            assign x_in = x_reg[g-1];
            assign r_in = rem_reg[g-1];
            assign d_in = den_reg[g-1];
        end

        assign r_sh = {r_in, x_in[NW-1]};
        assign ge   = r_sh >= {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[g]   <= {x_in[NW-2:0], ge};
                rem_reg[g] <= ge ? DW'(r_sh - {1'b0, d_in}) : r_sh[DW-1:0];
                den_reg[g] <= d_in;
            end
        end
    end

    assign quo = x_reg[NW-1];

endmodule

@@ sv/ray_sphere_hit.sv @@
// Ray against one configured sphere: quadratic test, hit point, normal.
//
// Channel  Dir  Handshake            Word
// s_*      in   s_tvalid / s_tready  ray: origin, direction, t bounds
// m_*      out  m_tvalid / m_tready  hit record, m_tuser = hit
// cfg_*    in   cfg_we               center, radius, material registers
//
// One word per clock while the output is not stalled. The pipeline holds
// NCH = ceil((2*COORD_WIDTH+1)/16) multiply chunks, the bit-per-stage square
// root and the root and normal divider chains. Reset clears the valid bits,
// the center and material registers, sets radius to 1 << FRAC_BITS; a stalled
// output word freezes the whole pipeline, nothing is dropped or repeated.
`include "ray_sphere_hit_assert.svh"

module ray_sphere_hit
    import rsh_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper
    input  logic [8*COORD_WIDTH-1:0]                      s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // hit_distance, point_x/y/z, normal_x/y/z, front_face, hit_material
    output logic [((7*COORD_WIDTH+17+7)/8)*8-1:0]         m_tdata,
    // hit
    output logic                                          m_tuser,
    input  logic                                          cfg_we,
    input  logic [CFG_IDX_BITS-1:0]                       cfg_index,
    input  logic [COORD_WIDTH-1:0]                        cfg_data
);

    localparam int W      = COORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int CK     = CHUNK_BITS;
    localparam int OCW    = W + 1;
    localparam int AW     = 2 * W;
    localparam int HW     = 2 * W + 2;
    localparam int HMW    = 2 * W + 1;
    localparam int CW     = 2 * W + 3;
    localparam int NCH    = (HMW + CK - 1) / CK;
    localparam int PADW   = NCH * CK;
    localparam int HHW    = 4 * W + 2;
    localparam int ACW    = 4 * W + 3;
    localparam int DSW    = 4 * W + 4;
    localparam int SW     = 2 * W + 1;
    localparam int RW     = SW + 2;
    localparam int VW     = 2 * SW;
    localparam int NUMW   = 2 * W + 3;
    localparam int NMW    = 2 * W + 2;
    localparam int NWT    = NMW + F;
    localparam int TW     = NWT + 1;
    localparam int PW     = 2 * W;
    localparam int PSW    = 2 * W - F + 1;
    localparam int NWN    = W + F;
    localparam int NOW    = NWN + 1;
    localparam int DOTW   = 2 * W + 2;
    localparam int OUT_BITS = 7 * W + 1 + MATERIAL_BITS;
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;
    localparam int LAT    = 12 + NCH + SW + NWT + NWN;

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0][W-1:0] o;
        logic [2:0][W-1:0] d;
        logic [W-1:0]      tl;
        logic [W-1:0]      tu;
    } ray_t;

    typedef struct packed {
        ray_t          ray;
        logic [HW-1:0] h;
        logic [AW-1:0] a;
        logic          pos;
    } geo_t;

    typedef struct packed {
        ray_t ray;
        logic pos;
        logic neg_n;
        logic neg_f;
    } root_t;

    typedef struct packed {
        logic              hit;
        logic [W-1:0]      t;
        logic [2:0][W-1:0] p;
        logic [2:0][W-1:0] d;
        logic [2:0]        neg;
    } hitp_t;

    function automatic logic [W-1:0] sat_p(input logic signed [PSW-1:0] v);
        logic signed [PSW-1:0] hi;
        logic signed [PSW-1:0] lo;
        hi = PSW'($signed(MAXV));
        lo = PSW'($signed(MINV));
        if (v > hi)
            sat_p = MAXV;
        else if (v < lo)
            sat_p = MINV;
        else
            sat_p = v[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_n(input logic signed [NOW-1:0] v);
        logic signed [NOW-1:0] hi;
        logic signed [NOW-1:0] lo;
        hi = NOW'($signed(MAXV));
        lo = NOW'($signed(MINV));
        if (v > hi)
            sat_n = MAXV;
        else if (v < lo)
            sat_n = MINV;
        else
            sat_n = v[W-1:0];
    endfunction

    // ---------------- config registers ----------------
    logic [2:0][W-1:0]        center_reg;
    logic [W-2:0]             radius_reg;
    logic [MATERIAL_BITS-1:0] material_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg   <= '0;
            radius_reg   <= (W-1)'(1) << F;
            material_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X: center_reg[0] <= cfg_data;
                CFG_CENTER_Y: center_reg[1] <= cfg_data;
                CFG_CENTER_Z: center_reg[2] <= cfg_data;
                CFG_RADIUS:   radius_reg    <= cfg_data[W-2:0];
                CFG_MATERIAL: material_reg  <= cfg_data[MATERIAL_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end

    // ---------------- stage 1: oc = origin - center ----------------
    ray_t                  in_ray;
    ray_t                  s1_ray_reg;
    logic signed [OCW-1:0] s1_oc_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_ray.o[i] = s_tdata[i*W +: W];
            in_ray.d[i] = s_tdata[(3+i)*W +: W];
        end
        in_ray.tl = s_tdata[6*W +: W];
        in_ray.tu = s_tdata[7*W +: W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ray_reg <= in_ray;
            for (int i = 0; i < 3; i++)
                s1_oc_reg[i] <= OCW'($signed(in_ray.o[i])) - OCW'($signed(center_reg[i]));
        end
    end

    // ---------------- stage 2: products ----------------
    ray_t                      s2_ray_reg;
    logic signed [PW-1:0]      s2_dd_reg [3];
    logic signed [OCW+W-1:0]   s2_od_reg [3];
    logic signed [2*OCW-1:0]   s2_oo_reg [3];
    logic [2*W-3:0]            s2_rr_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ray_reg <= s1_ray_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_dd_reg[i] <= $signed(s1_ray_reg.d[i]) * $signed(s1_ray_reg.d[i]);
                s2_od_reg[i] <= s1_oc_reg[i] * $signed(s1_ray_reg.d[i]);
                s2_oo_reg[i] <= s1_oc_reg[i] * s1_oc_reg[i];
            end
            s2_rr_reg <= radius_reg * radius_reg;
        end
    end

    // ---------------- stage 3: a, h, c ----------------
    logic [AW-1:0]         a_sum;
    logic signed [HW-1:0]  h_sum;
    logic signed [CW-1:0]  c_sum;
    logic [HMW-1:0]        h_mag;
    geo_t                  s3_geo_reg;
    logic [HMW-1:0]        s3_hmag_reg;
    logic signed [CW-1:0]  s3_c_reg;

    always_comb
    begin
        a_sum = AW'(s2_dd_reg[0]) + AW'(s2_dd_reg[1]) + AW'(s2_dd_reg[2]);
        h_sum = HW'(s2_od_reg[0]) + HW'(s2_od_reg[1]) + HW'(s2_od_reg[2]);
        c_sum = CW'(s2_oo_reg[0]) + CW'(s2_oo_reg[1]) + CW'(s2_oo_reg[2])
              - CW'({1'b0, s2_rr_reg});
        h_mag = h_sum[HW-1] ? HMW'(-h_sum) : HMW'(h_sum);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_geo_reg.ray <= s2_ray_reg;
            s3_geo_reg.h   <= h_sum;
            s3_geo_reg.a   <= a_sum;
            s3_geo_reg.pos <= 1'b0;
            s3_hmag_reg    <= h_mag;
            s3_c_reg       <= c_sum;
        end
    end

    // ---------------- h*h and a*c, one chunk per stage ----------------
    logic [PADW-1:0]       mul_hm_reg [NCH];
    logic [PADW-1:0]       mul_a_reg  [NCH];
    logic signed [CW-1:0]  mul_c_reg  [NCH];
    logic [HHW-1:0]        mul_hh_reg [NCH];
    logic signed [ACW-1:0] mul_ac_reg [NCH];
    geo_t                  mul_geo_reg [NCH];

    for (genvar k = 0; k < NCH; k++) begin : g_mul
        logic [PADW-1:0]         hm_in;
        logic [PADW-1:0]         a_in;
        logic signed [CW-1:0]    c_in;
        logic [HHW-1:0]          hh_in;
        logic signed [ACW-1:0]   ac_in;
        geo_t                    geo_in;
        logic [HMW+CK-1:0]       hterm;
        logic signed [CW+CK:0]   cterm;

        if (k == 0) begin : g_first
            assign hm_in  = PADW'(s3_hmag_reg);
            assign a_in   = PADW'(s3_geo_reg.a);
            assign c_in   = s3_c_reg;
            assign hh_in  = '0;
            assign ac_in  = '0;
            assign geo_in = s3_geo_reg;
        end
        else begin : g_rest
            assign hm_in  = mul_hm_reg[k-1];
            assign a_in   = mul_a_reg[k-1];
            assign c_in   = mul_c_reg[k-1];
            assign hh_in  = mul_hh_reg[k-1];
            assign ac_in  = mul_ac_reg[k-1];
            assign geo_in = mul_geo_reg[k-1];
        end

        assign hterm = hm_in[HMW-1:0] * hm_in[k*CK +: CK];
        assign cterm = c_in * $signed({1'b0, a_in[k*CK +: CK]});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mul_hm_reg[k]  <= hm_in;
                mul_a_reg[k]   <= a_in;
                mul_c_reg[k]   <= c_in;
                mul_hh_reg[k]  <= hh_in + (HHW'(hterm) << (k*CK));
                mul_ac_reg[k]  <= ac_in + (ACW'(cterm) << (k*CK));
                mul_geo_reg[k] <= geo_in;
            end
        end
    end

    // ---------------- discriminant ----------------
    logic signed [DSW-1:0] disc_c;
    logic [VW-1:0]         ds_v_reg;
    geo_t                  ds_geo_reg;

    assign disc_c = DSW'({1'b0, mul_hh_reg[NCH-1]}) - DSW'(mul_ac_reg[NCH-1]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ds_v_reg       <= disc_c[VW-1:0];
            ds_geo_reg.ray <= mul_geo_reg[NCH-1].ray;
            ds_geo_reg.h   <= mul_geo_reg[NCH-1].h;
            ds_geo_reg.a   <= mul_geo_reg[NCH-1].a;
            ds_geo_reg.pos <= !disc_c[DSW-1] && (disc_c != '0);
        end
    end

    // ---------------- integer square root, one bit per stage ----------------
    logic [RW-1:0] sq_rem_reg  [SW];
    logic [SW-1:0] sq_root_reg [SW];
    logic [VW-1:0] sq_v_reg    [SW];
    geo_t          sq_geo_reg  [SW];

    for (genvar j = 0; j < SW; j++) begin : g_sqrt
        logic [RW-1:0] rem_in;
        logic [SW-1:0] root_in;
        logic [VW-1:0] v_in;
        geo_t          geo_in;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          ge;

        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = ds_v_reg;
            assign geo_in  = ds_geo_reg;
        end
        else begin : g_rest
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
            assign v_in    = sq_v_reg[j-1];
            assign geo_in  = sq_geo_reg[j-1];
        end

        assign rem_sh = {rem_in[RW-3:0], v_in[VW-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[j]  <= ge ? rem_sh - trial : rem_sh;
                sq_root_reg[j] <= {root_in[SW-2:0], ge};
                sq_v_reg[j]    <= {v_in[VW-3:0], 2'b00};
                sq_geo_reg[j]  <= geo_in;
            end
        end
    end

    // ---------------- root numerators ----------------
    logic signed [NUMW-1:0] h_x;
    logic signed [NUMW-1:0] s_x;
    logic signed [NUMW-1:0] num_n;
    logic signed [NUMW-1:0] num_f;
    logic [NMW-1:0]         nm_magn_reg;
    logic [NMW-1:0]         nm_magf_reg;
    logic [AW-1:0]          nm_a_reg;
    root_t                  nm_root_reg;

    always_comb
    begin
        h_x   = NUMW'($signed(sq_geo_reg[SW-1].h));
        s_x   = $signed(NUMW'(sq_root_reg[SW-1]));
        num_n = -h_x - s_x;
        num_f = -h_x + s_x;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nm_magn_reg       <= num_n[NUMW-1] ? NMW'(-num_n) : NMW'(num_n);
            nm_magf_reg       <= num_f[NUMW-1] ? NMW'(-num_f) : NMW'(num_f);
            nm_a_reg          <= sq_geo_reg[SW-1].a;
            nm_root_reg.ray   <= sq_geo_reg[SW-1].ray;
            nm_root_reg.pos   <= sq_geo_reg[SW-1].pos;
            nm_root_reg.neg_n <= num_n[NUMW-1];
            nm_root_reg.neg_f <= num_f[NUMW-1];
        end
    end

    // ---------------- root divides ----------------
    logic [NWT-1:0] qn;
    logic [NWT-1:0] qf;
    root_t          rt_reg [NWT];

    rsh_div #(.NW(NWT), .DW(AW)) u_div_near (
        .clk (clk),
        .en  (adv),
        .num ({nm_magn_reg, {F{1'b0}}}),
        .den (nm_a_reg),
        .quo (qn)
    );

    rsh_div #(.NW(NWT), .DW(AW)) u_div_far (
        .clk (clk),
        .en  (adv),
        .num ({nm_magf_reg, {F{1'b0}}}),
        .den (nm_a_reg),
        .quo (qf)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rt_reg[0] <= nm_root_reg;
            for (int i = 1; i < NWT; i++)
                rt_reg[i] <= rt_reg[i-1];
        end
    end

    // ---------------- root select ----------------
    logic signed [TW-1:0] tn_c;
    logic signed [TW-1:0] tf_c;
    logic signed [TW-1:0] tl_c;
    logic signed [TW-1:0] tu_c;
    logic                 hn_c;
    logic                 hf_c;
    logic                 sel_hit_reg;
    logic [W-1:0]         sel_t_reg;
    ray_t                 sel_ray_reg;

    always_comb
    begin
        tn_c = rt_reg[NWT-1].neg_n ? -$signed(TW'(qn)) : $signed(TW'(qn));
        tf_c = rt_reg[NWT-1].neg_f ? -$signed(TW'(qf)) : $signed(TW'(qf));
        tl_c = TW'($signed(rt_reg[NWT-1].ray.tl));
        tu_c = TW'($signed(rt_reg[NWT-1].ray.tu));
        hn_c = rt_reg[NWT-1].pos && (tn_c > tl_c) && (tn_c < tu_c);
        hf_c = rt_reg[NWT-1].pos && (tf_c > tl_c) && (tf_c < tu_c);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_hit_reg <= hn_c || hf_c;
            sel_t_reg   <= hn_c ? tn_c[W-1:0] : tf_c[W-1:0];
            sel_ray_reg <= rt_reg[NWT-1].ray;
        end
    end

    // ---------------- t * dir ----------------
    logic signed [PW-1:0] tp_reg [3];
    logic                 tp_hit_reg;
    logic [W-1:0]         tp_t_reg;
    ray_t                 tp_ray_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                tp_reg[i] <= $signed(sel_t_reg) * $signed(sel_ray_reg.d[i]);
            tp_hit_reg <= sel_hit_reg;
            tp_t_reg   <= sel_t_reg;
            tp_ray_reg <= sel_ray_reg;
        end
    end

    // ---------------- hit point ----------------
    hitp_t pt_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                pt_reg.p[i] <= sat_p(PSW'($signed(tp_ray_reg.o[i])) + PSW'(tp_reg[i] >>> F));
            pt_reg.hit <= tp_hit_reg;
            pt_reg.t   <= tp_t_reg;
            pt_reg.d   <= tp_ray_reg.d;
            pt_reg.neg <= '0;
        end
    end

    // ---------------- normal numerators ----------------
    logic signed [W:0] diff_c [3];
    logic [NWN-1:0]    np_num_reg [3];
    hitp_t             np_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            diff_c[i] = (W+1)'($signed(pt_reg.p[i])) - (W+1)'($signed(center_reg[i]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                np_num_reg[i] <= {(diff_c[i][W] ? W'(-diff_c[i]) : W'(diff_c[i])),
                                  {F{1'b0}}};
                np_reg.neg[i] <= diff_c[i][W];
            end
            np_reg.hit <= pt_reg.hit;
            np_reg.t   <= pt_reg.t;
            np_reg.p   <= pt_reg.p;
            np_reg.d   <= pt_reg.d;
        end
    end

    // ---------------- normal divides ----------------
    logic [NWN-1:0] nq [3];
    hitp_t          nd_reg [NWN];

    for (genvar ax = 0; ax < 3; ax++) begin : g_ndiv
        rsh_div #(.NW(NWN), .DW(W-1)) u_div_norm (
            .clk (clk),
            .en  (adv),
            .num (np_num_reg[ax]),
            .den (radius_reg),
            .quo (nq[ax])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nd_reg[0] <= np_reg;
            for (int i = 1; i < NWN; i++)
                nd_reg[i] <= nd_reg[i-1];
        end
    end

    // ---------------- normal sign and clamp ----------------
    logic [W-1:0] ns_no_reg [3];
    hitp_t        ns_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                ns_no_reg[i] <= sat_n(nd_reg[NWN-1].neg[i] ? -$signed(NOW'(nq[i]))
                                                           : $signed(NOW'(nq[i])));
            ns_reg <= nd_reg[NWN-1];
        end
    end

    // ---------------- dir . normal products ----------------
    logic signed [PW-1:0] dp_prod_reg [3];
    logic [W-1:0]         dp_no_reg [3];
    hitp_t                dp_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dp_prod_reg[i] <= $signed(ns_reg.d[i]) * $signed(ns_no_reg[i]);
                dp_no_reg[i]   <= ns_no_reg[i];
            end
            dp_reg <= ns_reg;
        end
    end

    // ---------------- output word ----------------
    logic signed [DOTW-1:0] dot_c;
    logic                   front_c;
    logic [W-1:0]           nrm_c [3];
    logic [OUT_BITS-1:0]    word_c;
    logic [OUT_TW-1:0]      out_data_reg;
    logic                   out_hit_reg;

    always_comb
    begin
        dot_c   = DOTW'(dp_prod_reg[0]) + DOTW'(dp_prod_reg[1]) + DOTW'(dp_prod_reg[2]);
        front_c = dot_c[DOTW-1];
        for (int i = 0; i < 3; i++)
        begin
            if (front_c)
                nrm_c[i] = dp_no_reg[i];
            else if (dp_no_reg[i] == MINV)
                nrm_c[i] = MAXV;
            else
                nrm_c[i] = -dp_no_reg[i];
        end
        word_c = {material_reg, front_c, nrm_c[2], nrm_c[1], nrm_c[0],
                  dp_reg.p[2], dp_reg.p[1], dp_reg.p[0], dp_reg.t};
        if (!dp_reg.hit)
            word_c = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= OUT_TW'(word_c);
            out_hit_reg  <= dp_reg.hit;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_hit_reg;

    // ---------------- checks ----------------
    `RSH_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "miss word has data")
    `RSH_ASSERT_IMP(a_hit_material, m_tvalid && m_tuser,
        m_tdata[7*W+MATERIAL_BITS:7*W+1] == material_reg, "hit word material mismatch")
    `RSH_ASSERT_NEXT(a_stall_freeze, m_tvalid && !m_tready, $stable(vld_reg),
        "pipeline moved during output stall")

endmodule
